>>> rtl/core/hdt_pkg.sv
`timescale 1ns / 1ps

package hdt_pkg;

   // coordinate and iteration settings
   localparam int COORD_WIDTH  = 16;
   localparam int CORDIC_STEPS = 18;

   // difference vector and its magnitude
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int ABS_W  = COORD_WIDTH;

   // cordic datapath
   localparam int GUARD      = 24;
   localparam int XY_W       = COORD_WIDTH + GUARD + 4;
   localparam int EXT_W      = XY_W - DIFF_W - GUARD;
   localparam int Z_W        = 30;
   localparam int DEG90      = 94371840;
   localparam int ROUND_HALF = 2048;
   localparam int HEAD_SHIFT = 12;

   // result fields
   localparam int HEAD_W   = 17;
   localparam int DIST_W   = 17;
   localparam int HEAD_MAX = 46080;
   localparam int DIST_MAX = (2 ** DIST_W) - 1;

   // distance: squares, radicand and digit-by-digit root
   localparam int SQ_W   = DIST_W;
   localparam int SUM_W  = 2 * SQ_W + 1;
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   // shared iteration counter
   localparam int ITER_N = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;
   localparam int CNT_W  = $clog2(ITER_N);

   // controller to datapath commands
   typedef struct packed {
      logic             load;
      logic             sq_x;
      logic             sq_y;
      logic             sum;
      logic             iter;
      logic             finish;
      logic [CNT_W-1:0] cnt;
   } dp_cmd_type;

   // atan(2^-i) in 2^-20 degree
   function automatic logic signed [Z_W-1:0] atan_angle(input logic [4:0] idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         5'd0:  a = Z_W'(47185920);
         5'd1:  a = Z_W'(27855475);
         5'd2:  a = Z_W'(14718068);
         5'd3:  a = Z_W'(7471121);
         5'd4:  a = Z_W'(3750058);
         5'd5:  a = Z_W'(1876857);
         5'd6:  a = Z_W'(938658);
         5'd7:  a = Z_W'(469357);
         5'd8:  a = Z_W'(234682);
         5'd9:  a = Z_W'(117342);
         5'd10: a = Z_W'(58671);
         5'd11: a = Z_W'(29335);
         5'd12: a = Z_W'(14668);
         5'd13: a = Z_W'(7334);
         5'd14: a = Z_W'(3667);
         5'd15: a = Z_W'(1833);
         5'd16: a = Z_W'(917);
         5'd17: a = Z_W'(458);
         5'd18: a = Z_W'(229);
         5'd19: a = Z_W'(115);
         5'd20: a = Z_W'(57);
         5'd21: a = Z_W'(29);
         5'd22: a = Z_W'(14);
         5'd23: a = Z_W'(7);
         5'd24: a = Z_W'(4);
         5'd25: a = Z_W'(2);
         5'd26: a = Z_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/core/hdt_ctrl.sv
`timescale 1ns / 1ps

module hdt_ctrl
   import hdt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQX  = 6'b000010,
      ST_SQY  = 6'b000100,
      ST_SUM  = 6'b001000,
      ST_ITER = 6'b010000,
      ST_FIN  = 6'b100000
   } hdt_state_type;

   hdt_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.cnt      = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ITER_N - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/hdt_datapath.sv
`timescale 1ns / 1ps

module hdt_datapath
   import hdt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_current_x,
   input  logic signed [COORD_WIDTH-1:0] req_current_y,
   output logic signed [HEAD_W-1:0]      rsp_heading,
   output logic        [DIST_W-1:0]      rsp_distance,
   output logic                          rsp_heading_held
);

   // load stage
   logic signed [DIFF_W-1:0] dx_in, dy_in, ndx, ndy, px, py;
   logic signed [Z_W-1:0]    pz;
   logic [DIFF_W-1:0]        ax_wide, ay_wide;

   // magnitudes and squares
   logic [ABS_W-1:0] ax_ff, ay_ff;
   logic             big_ff, zero_ff;
   logic [2*SQ_W-1:0] sqx_ff, sqy_ff;

   // cordic
   logic signed [XY_W-1:0] x_ff, y_ff, xs, ys;
   logic signed [Z_W-1:0]  z_ff, ang;
   logic                   cordic_en;

   // square root
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_ff, rem_cat, trial;
   logic              sqrt_en;

   // finish
   logic signed [Z_W-1:0] z_rnd, h_wide, h_clamp;
   logic [ROOT_W:0]       dist_wide;
   logic [DIST_W-1:0]     dist_sat;

   logic signed [HEAD_W-1:0] last_heading_ff;
   logic signed [HEAD_W-1:0] rsp_heading_ff;
   logic [DIST_W-1:0]        rsp_distance_ff;
   logic                     rsp_heading_held_ff;

   assign rsp_heading      = rsp_heading_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_heading_held = rsp_heading_held_ff;

   // difference vector and rotation into the right half plane
   always_comb begin
      dx_in   = DIFF_W'(req_target_x) - DIFF_W'(req_current_x);
      dy_in   = DIFF_W'(req_target_y) - DIFF_W'(req_current_y);
      ndx     = -dx_in;
      ndy     = -dy_in;
      ax_wide = dx_in[DIFF_W-1] ? ndx : dx_in;
      ay_wide = dy_in[DIFF_W-1] ? ndy : dy_in;
      if (!dx_in[DIFF_W-1]) begin
         px = dx_in;
         py = dy_in;
         pz = '0;
      end else if (!dy_in[DIFF_W-1]) begin
         px = dy_in;
         py = ndx;
         pz = Z_W'(DEG90);
      end else begin
         px = ndy;
         py = dx_in;
         pz = -Z_W'(DEG90);
      end
   end

   // one cordic micro-rotation per cycle
   assign cordic_en = cmd.iter && (cmd.cnt < CORDIC_STEPS);
   assign xs        = x_ff >>> cmd.cnt;
   assign ys        = y_ff >>> cmd.cnt;
   assign ang       = atan_angle(5'(cmd.cnt));

   // one root bit per cycle
   assign sqrt_en = cmd.iter && (cmd.cnt < ROOT_W);
   assign rem_cat = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial   = REM_W'({root_ff, 2'b01});

   always_comb begin
      z_rnd   = z_ff + Z_W'(ROUND_HALF);
      h_wide  = z_rnd >>> HEAD_SHIFT;
      h_clamp = h_wide;
      if (h_wide > Z_W'(HEAD_MAX)) begin
         h_clamp = Z_W'(HEAD_MAX);
      end else if (h_wide < -Z_W'(HEAD_MAX)) begin
         h_clamp = -Z_W'(HEAD_MAX);
      end
      // round to nearest: remainder above root means past the half point
      dist_wide = (ROOT_W + 1)'(root_ff) + (ROOT_W + 1)'(rem_ff > REM_W'(root_ff));
      if (big_ff || dist_wide > (ROOT_W + 1)'(DIST_MAX)) begin
         dist_sat = DIST_W'(DIST_MAX);
      end else begin
         dist_sat = dist_wide[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff   <= ax_wide[ABS_W-1:0];
         ay_ff   <= ay_wide[ABS_W-1:0];
         zero_ff <= (dx_in == '0) && (dy_in == '0);
         x_ff    <= {{EXT_W{px[DIFF_W-1]}}, px, {GUARD{1'b0}}};
         y_ff    <= {{EXT_W{py[DIFF_W-1]}}, py, {GUARD{1'b0}}};
         z_ff    <= pz;
      end else if (cordic_en) begin
         if (!y_ff[XY_W-1]) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end else begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end
      end
      if (cmd.sq_x) begin
         sqx_ff <= SQ_W'(ax_ff) * SQ_W'(ax_ff);
         big_ff <= (({1'b0, ax_ff} >> SQ_W) != '0) || (({1'b0, ay_ff} >> SQ_W) != '0);
      end
      if (cmd.sq_y) begin
         sqy_ff <= SQ_W'(ay_ff) * SQ_W'(ay_ff);
      end
      if (cmd.sum) begin
         rad_ff  <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (sqrt_en) begin
         rad_ff <= rad_ff << 2;
         if (rem_cat >= trial) begin
            rem_ff  <= rem_cat - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_cat;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         rsp_heading_held_ff <= zero_ff;
         rsp_heading_ff      <= zero_ff ? last_heading_ff : h_clamp[HEAD_W-1:0];
         rsp_distance_ff     <= zero_ff ? '0 : dist_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_heading_ff <= '0;
      end else if (cmd.finish && !zero_ff) begin
         last_heading_ff <= h_clamp[HEAD_W-1:0];
      end
   end

endmodule

>>> rtl/core/heading_and_distance_to_target_top.sv
`timescale 1ns / 1ps
// one word in flight: a word is taken only in idle, after the shared 18-step loop
// (cordic + root) and the finish step; a result still unread at finish holds the controller
// until taken
// a finished result waits in the output register while the next word is taken
// reset: synchronous, active high; clears the controller and the held heading to 0
module heading_and_distance_to_target_top
   import hdt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // input word
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_current_x,
   input  logic signed [COORD_WIDTH-1:0] req_current_y,
   // result word
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [HEAD_W-1:0]      rsp_heading,
   output logic        [DIST_W-1:0]      rsp_distance,
   output logic                          rsp_heading_held
);

   // command bundle from sequencer to datapath
   dp_cmd_type cmd;

   // sequencer: load, squaring of x and of y, radicand sum, iteration loop, finish
   hdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath: difference vector, vectoring cordic for the heading,
   // digit-by-digit square root for the distance, output register
   hdt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_current_x    (req_current_x),
      .req_current_y    (req_current_y),
      .rsp_heading      (rsp_heading),
      .rsp_distance     (rsp_distance),
      .rsp_heading_held (rsp_heading_held)
   );

   // coinciding positions always report zero distance
   a_held_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_heading_held |-> rsp_distance == '0)
      else $error("held heading with nonzero distance");

   // heading stays within the half-turn clamp
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading <= HEAD_W'(HEAD_MAX)) && (rsp_heading >= -HEAD_W'(HEAD_MAX)))
      else $error("heading outside clamp range");

   // one word at a time: taking a word closes the input
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input reopened right after accepting a word");

   // a new result is never loaded over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading) && $stable(rsp_distance))
      else $error("pending result overwritten");

endmodule

>>> verif/heading_and_distance_to_target_checker.sv
`timescale 1ns / 1ps
module heading_and_distance_to_target_checker
   import hdt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_target_x,
   input  logic signed [COORD_WIDTH-1:0] req_target_y,
   input  logic signed [COORD_WIDTH-1:0] req_current_x,
   input  logic signed [COORD_WIDTH-1:0] req_current_y,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [HEAD_W-1:0]      rsp_heading,
   input  logic        [DIST_W-1:0]      rsp_distance,
   input  logic                          rsp_heading_held,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      logic signed [HEAD_W-1:0] heading;
      logic        [DIST_W-1:0] distance;
      logic                     held;
   } nav_fix_type;

   // atan(2^-i) in 2^-20 degree
   localparam longint ATAN_Q20 [0:31] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7,
      4, 2, 1, 0, 0, 0, 0, 0
   };

   nav_fix_type              expected_fixes[$];
   nav_fix_type              want;
   nav_fix_type              fix;
   logic signed [HEAD_W-1:0] last_heading;
   int                       failures = 0;

   // vectoring rotation, result in 1/256 degree
   function automatic longint heading_of(longint dx, longint dy);
      longint x, y, z, xs, ys, h;
      if (dx >= 0) begin
         x = dx;  y = dy;  z = 0;
      end else if (dy >= 0) begin
         x = dy;  y = -dx; z = DEG90;
      end else begin
         x = -dy; y = dx;  z = -DEG90;
      end
      x = x <<< GUARD;
      y = y <<< GUARD;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ATAN_Q20[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ATAN_Q20[i];
         end
      end
      h = (z + ROUND_HALF) >>> HEAD_SHIFT;
      if (h > HEAD_MAX) h = HEAD_MAX;
      if (h < -HEAD_MAX) h = -HEAD_MAX;
      return h;
   endfunction

   // integer square root rounded to nearest
   function automatic longint length_of(longint ax, longint ay);
      longint unsigned rest, root, probe;
      rest  = ax * ax + ay * ay;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      if (rest > root) root++;
      return root;
   endfunction

   function automatic nav_fix_type locate_target(logic signed [HEAD_W-1:0] prev_heading);
      nav_fix_type f;
      longint      dx, dy, ax, ay, len;
      dx = longint'(req_target_x) - longint'(req_current_x);
      dy = longint'(req_target_y) - longint'(req_current_y);
      if (dx == 0 && dy == 0) begin
         f.heading  = prev_heading;
         f.distance = '0;
         f.held     = 1'b1;
      end else begin
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         if (ax >= (64'sd1 << 17) || ay >= (64'sd1 << 17)) len = DIST_MAX;
         else len = length_of(ax, ay);
         if (len > DIST_MAX) len = DIST_MAX;
         f.heading  = HEAD_W'(heading_of(dx, dy));
         f.distance = DIST_W'(len);
         f.held     = 1'b0;
      end
      return f;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_fixes.delete();
         last_heading = '0;
      end else begin
         // results first: a word accepted now cannot answer at this edge
         if (rsp_valid && rsp_ready) begin
            if (expected_fixes.size() == 0) begin
               $error("result word with nothing pending: heading %0d distance %0d held %0b",
                      rsp_heading, rsp_distance, rsp_heading_held);
               failures++;
            end else begin
               want = expected_fixes.pop_front();
               if (rsp_heading !== want.heading) begin
                  $error("heading: expected %0d, got %0d", want.heading, rsp_heading);
                  failures++;
               end
               if (rsp_distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
                  failures++;
               end
               if (rsp_heading_held !== want.held) begin
                  $error("heading_held: expected %0b, got %0b", want.held, rsp_heading_held);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            fix = locate_target(last_heading);
            if (!fix.held) last_heading = fix.heading;
            expected_fixes.push_back(fix);
         end
      end
      fail_count  <= failures;
      outstanding <= expected_fixes.size();
   end

endmodule

>>> verif/heading_and_distance_to_target_top_test.sv
`timescale 1ns / 1ps
module heading_and_distance_to_target_top_test;
   import hdt_pkg::*;

   // cycles with no word moving on either channel before the run is called dead
   localparam int QUIET_LIMIT    = 5000;
   // settle time after the last result
   localparam int DRAIN_CYCLES   = 40;
   localparam int WORDS_PER_PASS = 475;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic signed [COORD_WIDTH-1:0] req_target_x  = '0;
   logic signed [COORD_WIDTH-1:0] req_target_y  = '0;
   logic signed [COORD_WIDTH-1:0] req_current_x = '0;
   logic signed [COORD_WIDTH-1:0] req_current_y = '0;

   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [HEAD_W-1:0]      rsp_heading;
   logic        [DIST_W-1:0]      rsp_distance;
   logic                          rsp_heading_held;

   int fail_count;
   int outstanding;

   // idle odds in percent for each side, changed per pass
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int quiet_cycles = 0;
   int words_sent   = 0;
   int zero_words   = 0;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   heading_and_distance_to_target_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_current_x    (req_current_x),
      .req_current_y    (req_current_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heading      (rsp_heading),
      .rsp_distance     (rsp_distance),
      .rsp_heading_held (rsp_heading_held)
   );

   // watches both channels, predicts each result word and compares it
   heading_and_distance_to_target_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_current_x    (req_current_x),
      .req_current_y    (req_current_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_heading      (rsp_heading),
      .rsp_distance     (rsp_distance),
      .rsp_heading_held (rsp_heading_held),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
      end
   end

   // watchdog: any accepted word on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offers one word and returns at the edge that accepts it; valid is left
   // high so a back-to-back word never lowers and raises it in one step
   task automatic send_word(input logic signed [COORD_WIDTH-1:0] tx,
                            input logic signed [COORD_WIDTH-1:0] ty,
                            input logic signed [COORD_WIDTH-1:0] cx,
                            input logic signed [COORD_WIDTH-1:0] cy);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_target_x  <= tx;
      req_target_y  <= ty;
      req_current_x <= cx;
      req_current_y <= cy;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (tx == cx && ty == cy) zero_words++;
   endtask

   // drop valid and hold off until every pending result word is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int                            kind;
      logic signed [COORD_WIDTH-1:0] tx, ty, cx, cy, off;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // coincident positions straight after reset repeat the cleared heading
      send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_word(16'sd5, 16'sd5, 16'sd5, 16'sd5);
      // unit steps along both axes and the four diagonals
      send_word(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_word(16'sd0, 16'sd1, 16'sd0, 16'sd0);
      send_word(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_word(16'sd0, -16'sd1, 16'sd0, 16'sd0);
      send_word(16'sd1, 16'sd1, 16'sd0, 16'sd0);
      send_word(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
      send_word(-16'sd1, 16'sd1, 16'sd0, 16'sd0);
      send_word(16'sd1, -16'sd1, 16'sd0, 16'sd0);
      // largest spans, giving the longest distance
      send_word(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
      send_word(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
      send_word(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      // straight behind and just either side of it, where the heading clamps
      send_word(16'sh8000, 16'sd0, 16'sh7fff, 16'sd0);
      send_word(16'sh8000, -16'sd1, 16'sh7fff, 16'sd0);
      send_word(16'sh8000, 16'sd0, 16'sh7fff, -16'sd1);
      // coincident after a real heading keeps that heading, twice in a row
      send_word(16'sd100, -16'sd200, 16'sd100, -16'sd200);
      send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(16'sd3, 16'sd4, 16'sd0, 16'sd0);
      send_word(16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
      send_word(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);

      // sender pauses until the block has answered everything
      wait_drained();

      // passes: no idling, sender idling, receiver stalling, both
      for (int pass = 0; pass < 4; pass++) begin
         send_idle_pct   = (pass == 1) ? 83 : (pass == 3) ? 21 : 0;
         recv_stall_pct <= (pass == 2) ? 83 : (pass == 3) ? 21 : 0;
         for (int n = 0; n < WORDS_PER_PASS; n++) begin
            kind = int'($urandom_range(99));
            tx   = COORD_WIDTH'($urandom);
            ty   = COORD_WIDTH'($urandom);
            cx   = COORD_WIDTH'($urandom);
            cy   = COORD_WIDTH'($urandom);
            off  = COORD_WIDTH'($urandom_range(64) - 32);
            if (kind < 40) begin
               // anywhere on the plane
            end else if (kind < 70) begin
               // nearby target, small difference vector
               cx = tx - off;
               cy = ty - COORD_WIDTH'($urandom_range(64) - 32);
            end else if (kind < 80) begin
               // on an axis
               if (kind[0]) cy = ty;
               else cx = tx;
            end else if (kind < 90) begin
               // on a diagonal
               off = COORD_WIDTH'($urandom);
               cx  = tx - off;
               cy  = kind[0] ? ty - off : ty + off;
            end else begin
               // coincident, heading is repeated
               cx = tx;
               cy = ty;
            end
            send_word(tx, ty, cx, cy);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words (%0d with coincident positions): axes, diagonals,",
               words_sent, zero_words);
      $display("extreme spans and near-180 clamping under four idle and stall mixes");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
